[src/asfd_pkg.sv]
// ---------------------------------------------------------------------------
// asfd_pkg
// Shared types and constants for the air sensor frame decoder.
// ---------------------------------------------------------------------------
package asfd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned IDX_W   = 5;
    localparam int unsigned RAW_W   = 16;
    localparam int unsigned PM_W    = 16;
    localparam int unsigned TVOC_W  = 17;
    localparam int unsigned TEMP_W  = 14;
    localparam int unsigned HUMID_W = 13;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 17;
    localparam int unsigned OUT_DATA_W = 80;

    // frame layout
    localparam logic [BYTE_W-1:0] HDR_A = 8'h16;
    localparam logic [BYTE_W-1:0] HDR_B = 8'h13;
    localparam logic [IDX_W-1:0] IDX_HDR0     = 5'd0;
    localparam logic [IDX_W-1:0] IDX_HDR1     = 5'd1;
    localparam logic [IDX_W-1:0] IDX_HDR2     = 5'd2;
    localparam logic [IDX_W-1:0] IDX_TVOC_HI  = 5'd3;
    localparam logic [IDX_W-1:0] IDX_TVOC_LO  = 5'd4;
    localparam logic [IDX_W-1:0] IDX_PM25_HI  = 5'd9;
    localparam logic [IDX_W-1:0] IDX_PM25_LO  = 5'd10;
    localparam logic [IDX_W-1:0] IDX_PM10_HI  = 5'd11;
    localparam logic [IDX_W-1:0] IDX_PM10_LO  = 5'd12;
    localparam logic [IDX_W-1:0] IDX_TEMP_HI  = 5'd13;
    localparam logic [IDX_W-1:0] IDX_TEMP_LO  = 5'd14;
    localparam logic [IDX_W-1:0] IDX_HUMID_HI = 5'd15;
    localparam logic [IDX_W-1:0] IDX_HUMID_LO = 5'd16;
    localparam logic [IDX_W-1:0] IDX_LAST     = 5'd21;

    // conversion constants
    localparam logic [RAW_W-1:0] TEMP_OFFSET = 16'd500;
    // floor(x / 100) = (x * TVOC_RECIP) >> 30, exact for x < 2^30 / 76
    localparam logic [23:0] TVOC_RECIP = 24'd10737419;
    // floor(x / 10) = (x * DIV10_RECIP) >> 19, exact for x < 2^18
    localparam logic [16:0] DIV10_RECIP = 17'd52429;

    // limit reset values
    localparam logic [PM_W-1:0]    PM25_LIMIT_RST  = 16'd999;
    localparam logic [PM_W-1:0]    PM10_LIMIT_RST  = 16'd999;
    localparam logic [TVOC_W-1:0]  TVOC_LIMIT_RST  = 17'd9999;
    localparam logic [HUMID_W-1:0] HUMID_LIMIT_RST = 13'd100;
    localparam logic signed [TEMP_W-1:0] TEMP_UPPER_RST = 14'sd60;
    localparam logic signed [TEMP_W-1:0] TEMP_LOWER_RST = -14'sd20;

    typedef enum logic [1:0] {
        ST_GOOD = 2'd0,
        ST_HDR  = 2'd1,
        ST_SUM  = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PM25_LIMIT  = 3'd0,
        REG_PM10_LIMIT  = 3'd1,
        REG_TVOC_LIMIT  = 3'd2,
        REG_HUMID_LIMIT = 3'd3,
        REG_TEMP_UPPER  = 3'd4,
        REG_TEMP_LOWER  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [RAW_W-1:0] tvoc;
        logic [RAW_W-1:0] pm25;
        logic [RAW_W-1:0] pm10;
        logic [RAW_W-1:0] temp;
        logic [RAW_W-1:0] humid;
    } t_raw;

    typedef struct packed {
        logic    done;
        t_status status;
    } t_frame_evt;

endpackage

[src/asfd_capture.sv]
// ---------------------------------------------------------------------------
// asfd_capture
// Frame tracking, running checksum, header check and raw field capture.
// ---------------------------------------------------------------------------
module asfd_capture (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [asfd_pkg::BYTE_W-1:0]   i_rx_byte,
    input  logic                          i_frame_start,
    output asfd_pkg::t_raw                o_raw,
    output asfd_pkg::t_frame_evt          o_evt,
    output logic                          o_last_next
);
    import asfd_pkg::*;

    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_in_frame, n_in_frame;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic              r_hdr_good, n_hdr_good;
    t_raw              r_raw;

    logic [IDX_W-1:0]  idx_cur;
    logic [BYTE_W-1:0] sum_base;
    logic              hdr_base;
    logic              active;

    always_comb begin
        active   = i_accept && (i_frame_start || r_in_frame);
        idx_cur  = i_frame_start ? IDX_HDR0 : r_idx;
        sum_base = i_frame_start ? '0 : r_sum;
        hdr_base = i_frame_start ? 1'b1 : r_hdr_good;

        n_idx      = r_idx;
        n_in_frame = r_in_frame;
        n_sum      = r_sum;
        n_hdr_good = r_hdr_good;
        o_evt.done   = 1'b0;
        o_evt.status = ST_GOOD;

        if (active) begin
            n_sum      = sum_base + i_rx_byte;
            n_hdr_good = hdr_base;
            case (idx_cur)
                IDX_HDR0, IDX_HDR2: n_hdr_good = hdr_base && (i_rx_byte == HDR_A);
                IDX_HDR1:           n_hdr_good = hdr_base && (i_rx_byte == HDR_B);
                default:            n_hdr_good = hdr_base;
            endcase
            if (idx_cur == IDX_LAST) begin
                n_idx      = '0;
                n_in_frame = 1'b0;
                o_evt.done = 1'b1;
                if (!n_hdr_good) begin
                    o_evt.status = ST_HDR;
                end else if (n_sum != '0) begin
                    o_evt.status = ST_SUM;
                end
            end else begin
                n_idx      = idx_cur + 1'b1;
                n_in_frame = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_in_frame <= 1'b0;
            r_sum      <= '0;
            r_hdr_good <= 1'b1;
        end else begin
            r_idx      <= n_idx;
            r_in_frame <= n_in_frame;
            r_sum      <= n_sum;
            r_hdr_good <= n_hdr_good;
        end
    end

    // big-endian fields, high byte first
    always_ff @(posedge i_clk) begin
        if (active) begin
            case (idx_cur)
                IDX_TVOC_HI:  r_raw.tvoc[15:8]  <= i_rx_byte;
                IDX_TVOC_LO:  r_raw.tvoc[7:0]   <= i_rx_byte;
                IDX_PM25_HI:  r_raw.pm25[15:8]  <= i_rx_byte;
                IDX_PM25_LO:  r_raw.pm25[7:0]   <= i_rx_byte;
                IDX_PM10_HI:  r_raw.pm10[15:8]  <= i_rx_byte;
                IDX_PM10_LO:  r_raw.pm10[7:0]   <= i_rx_byte;
                IDX_TEMP_HI:  r_raw.temp[15:8]  <= i_rx_byte;
                IDX_TEMP_LO:  r_raw.temp[7:0]   <= i_rx_byte;
                IDX_HUMID_HI: r_raw.humid[15:8] <= i_rx_byte;
                IDX_HUMID_LO: r_raw.humid[7:0]  <= i_rx_byte;
                default: ;
            endcase
        end
    end

    assign o_raw       = r_raw;
    assign o_last_next = r_in_frame && (r_idx == IDX_LAST);

endmodule

[src/asfd_convert.sv]
// ---------------------------------------------------------------------------
// asfd_convert
// Two-stage unit scaling of the captured TVOC and temperature; humidity is scaled straight off its raw register.
// ---------------------------------------------------------------------------
module asfd_convert (
    input  logic                                 i_clk,
    input  asfd_pkg::t_raw                       i_raw,
    output logic        [asfd_pkg::TVOC_W-1:0]   o_tvoc,
    output logic signed [asfd_pkg::TEMP_W-1:0]   o_temp,
    output logic        [asfd_pkg::HUMID_W-1:0]  o_humid
);
    import asfd_pkg::*;

    // Free running on the raw registers. Fields settle at byte 16 at the
    // latest, five bytes before the frame ends, so two stages are in time.
    logic [23:0]      r_tvoc_x;
    logic             r_temp_neg;
    logic [RAW_W-1:0] r_temp_mag;

    logic [47:0]        tvoc_prod;
    logic [32:0]        temp_prod;
    logic [32:0]        humid_prod;
    logic [HUMID_W-1:0] temp_q;

    always_ff @(posedge i_clk) begin
        // raw * 136 = raw * 128 + raw * 8
        r_tvoc_x   <= {1'b0, i_raw.tvoc, 7'd0} + {5'd0, i_raw.tvoc, 3'd0};
        r_temp_neg <= (i_raw.temp < TEMP_OFFSET);
        r_temp_mag <= (i_raw.temp < TEMP_OFFSET) ? (TEMP_OFFSET - i_raw.temp)
                                                 : (i_raw.temp - TEMP_OFFSET);
    end

    always_comb begin
        tvoc_prod  = {24'd0, r_tvoc_x} * {24'd0, TVOC_RECIP};
        temp_prod  = {17'd0, r_temp_mag} * {16'd0, DIV10_RECIP};
        humid_prod = {17'd0, i_raw.humid} * {16'd0, DIV10_RECIP};
        temp_q     = temp_prod[31:19];
    end

    // quotient magnitude is truncated, so negation gives rounding toward zero
    always_ff @(posedge i_clk) begin
        o_tvoc  <= tvoc_prod[46:30];
        o_temp  <= r_temp_neg ? -$signed({1'b0, temp_q}) : $signed({1'b0, temp_q});
        o_humid <= humid_prod[31:19];
    end

endmodule

[src/asfd_result.sv]
// ---------------------------------------------------------------------------
// asfd_result
// Limit registers, clamping, last-good store and the output register.
// ---------------------------------------------------------------------------
module asfd_result (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    input  logic [asfd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [asfd_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  asfd_pkg::t_frame_evt                  i_evt,
    input  logic        [asfd_pkg::PM_W-1:0]      i_pm25,
    input  logic        [asfd_pkg::PM_W-1:0]      i_pm10,
    input  logic        [asfd_pkg::TVOC_W-1:0]    i_tvoc,
    input  logic signed [asfd_pkg::TEMP_W-1:0]    i_temp,
    input  logic        [asfd_pkg::HUMID_W-1:0]   i_humid,
    input  logic                                  i_m_tready,
    output logic                                  o_m_tvalid,
    output logic [1:0]                            o_m_tuser,
    output logic [asfd_pkg::OUT_DATA_W-1:0]       o_m_tdata
);
    import asfd_pkg::*;

    logic        [PM_W-1:0]    r_pm25_lim, r_pm10_lim;
    logic        [TVOC_W-1:0]  r_tvoc_lim;
    logic        [HUMID_W-1:0] r_humid_lim;
    logic signed [TEMP_W-1:0]  r_temp_up, r_temp_lo;

    logic        [PM_W-1:0]    r_last_pm25, r_last_pm10, n_last_pm25, n_last_pm10;
    logic        [TVOC_W-1:0]  r_last_tvoc, n_last_tvoc;
    logic signed [TEMP_W-1:0]  r_last_temp, n_last_temp;
    logic        [HUMID_W-1:0] r_last_humid, n_last_humid;
    logic                      r_valid, n_valid;
    t_status                   r_status;

    logic        [PM_W-1:0]    sel_pm25, sel_pm10;
    logic        [TVOC_W-1:0]  sel_tvoc;
    logic signed [TEMP_W-1:0]  sel_temp, temp_hi;
    logic        [HUMID_W-1:0] sel_humid;
    logic                      good;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pm25_lim  <= PM25_LIMIT_RST;
            r_pm10_lim  <= PM10_LIMIT_RST;
            r_tvoc_lim  <= TVOC_LIMIT_RST;
            r_humid_lim <= HUMID_LIMIT_RST;
            r_temp_up   <= TEMP_UPPER_RST;
            r_temp_lo   <= TEMP_LOWER_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_PM25_LIMIT:  r_pm25_lim  <= i_cfg_data[PM_W-1:0];
                REG_PM10_LIMIT:  r_pm10_lim  <= i_cfg_data[PM_W-1:0];
                REG_TVOC_LIMIT:  r_tvoc_lim  <= i_cfg_data[TVOC_W-1:0];
                REG_HUMID_LIMIT: r_humid_lim <= i_cfg_data[HUMID_W-1:0];
                REG_TEMP_UPPER:  r_temp_up   <= $signed(i_cfg_data[TEMP_W-1:0]);
                REG_TEMP_LOWER:  r_temp_lo   <= $signed(i_cfg_data[TEMP_W-1:0]);
                default: ;
            endcase
        end
    end

    // a bad frame re-clamps the stored values against the current limits
    always_comb begin
        good      = (i_evt.status == ST_GOOD);
        sel_pm25  = good ? i_pm25  : r_last_pm25;
        sel_pm10  = good ? i_pm10  : r_last_pm10;
        sel_tvoc  = good ? i_tvoc  : r_last_tvoc;
        sel_temp  = good ? i_temp  : r_last_temp;
        sel_humid = good ? i_humid : r_last_humid;

        temp_hi = (sel_temp > r_temp_up) ? r_temp_up : sel_temp;

        n_last_pm25  = r_last_pm25;
        n_last_pm10  = r_last_pm10;
        n_last_tvoc  = r_last_tvoc;
        n_last_temp  = r_last_temp;
        n_last_humid = r_last_humid;
        n_valid      = r_valid && !i_m_tready;

        if (i_evt.done) begin
            n_last_pm25  = (sel_pm25  > r_pm25_lim)  ? r_pm25_lim  : sel_pm25;
            n_last_pm10  = (sel_pm10  > r_pm10_lim)  ? r_pm10_lim  : sel_pm10;
            n_last_tvoc  = (sel_tvoc  > r_tvoc_lim)  ? r_tvoc_lim  : sel_tvoc;
            n_last_humid = (sel_humid > r_humid_lim) ? r_humid_lim : sel_humid;
            // lower limit applied last, so it wins when the limits cross
            n_last_temp  = (temp_hi < r_temp_lo) ? r_temp_lo : temp_hi;
            n_valid      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pm25  <= '0;
            r_last_pm10  <= '0;
            r_last_tvoc  <= '0;
            r_last_temp  <= '0;
            r_last_humid <= '0;
            r_valid      <= 1'b0;
            r_status     <= ST_GOOD;
        end else begin
            r_last_pm25  <= n_last_pm25;
            r_last_pm10  <= n_last_pm10;
            r_last_tvoc  <= n_last_tvoc;
            r_last_temp  <= n_last_temp;
            r_last_humid <= n_last_humid;
            r_valid      <= n_valid;
            if (i_evt.done) begin
                r_status <= i_evt.status;
            end
        end
    end

    // the last-good store doubles as the output data register
    assign o_m_tvalid = r_valid;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = {4'd0, r_last_humid, r_last_temp, r_last_tvoc,
                         r_last_pm10, r_last_pm25};

endmodule

[src/air_sensor_frame_decoder.sv]
// ---------------------------------------------------------------------------
// air_sensor_frame_decoder
// Decodes 22-byte air-quality sensor replies into clamped readings.
// ---------------------------------------------------------------------------
// One reply byte is taken per clock. A byte with tuser set opens a frame; bytes
// outside a frame are dropped. On the 22nd byte the result (status in tuser,
// readings in tdata) appears on the master side in the next cycle and stays
// until taken. The slave side only stalls when the next byte would close a
// frame while the previous result is still waiting, so with a ready sink the
// rate is one byte per cycle. Scaling runs in a two-stage unit off the captured
// fields, which settle five bytes before the frame ends. Limits must be written
// through the cfg port while no frame is in progress; nothing enforces this.
module air_sensor_frame_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // cfg port
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [asfd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [asfd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // byte stream in
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // [7:0] rx_byte
    input  logic                                s_axis_tuser,  // [0] frame_start
    // result stream out
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [15:0] pm25, [31:16] pm10, [48:32] tvoc, [62:49] temperature,
    // [75:63] humidity, [79:76] zero
    output logic [asfd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic [1:0]                          m_axis_tuser   // [1:0] status
);
    import asfd_pkg::*;

    t_raw               raw;
    t_frame_evt         evt;
    logic               last_next;
    logic               accept;
    logic [TVOC_W-1:0]  tvoc_conv;
    logic signed [TEMP_W-1:0] temp_conv;
    logic [HUMID_W-1:0] humid_conv;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !last_next || !m_axis_tvalid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    asfd_capture u_capture (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_rx_byte     (s_axis_tdata),
        .i_frame_start (s_axis_tuser),
        .o_raw         (raw),
        .o_evt         (evt),
        .o_last_next   (last_next)
    );

    asfd_convert u_convert (
        .i_clk   (i_clk),
        .i_raw   (raw),
        .o_tvoc  (tvoc_conv),
        .o_temp  (temp_conv),
        .o_humid (humid_conv)
    );

    asfd_result u_result (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_evt       (evt),
        .i_pm25      (raw.pm25),
        .i_pm10      (raw.pm10),
        .i_tvoc      (tvoc_conv),
        .i_temp      (temp_conv),
        .i_humid     (humid_conv),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tuser   (m_axis_tuser),
        .o_m_tdata   (m_axis_tdata)
    );

endmodule

[src/asfd_checker.sv]
// ---------------------------------------------------------------------------
// asfd_checker
// Port-level checks on the frame decoder, bound to the top level.
// ---------------------------------------------------------------------------
module asfd_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [asfd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input logic [1:0]                        m_axis_tuser
);
    // a waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // a result only appears right after a byte was taken
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("result without an accepted byte");

    // the byte side only stalls behind a result that is still waiting
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a waiting result");

    // with no result pending the byte side never stalls
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind air_sensor_frame_decoder asfd_checker u_asfd_checker (.*);
